/* design/tdwc_pkg.sv */
// Shared types, widths and register codes of the track/detection weighted cost unit.
`timescale 1ns / 1ps

package tdwc_pkg;

	// Coordinate width of the payload struct below. Valid from 16 to 32.
	localparam int COORD_WIDTH = 24;
	localparam int EXT_W       = 20;
	localparam int WGT_W       = 16;
	localparam int GATE_W      = 20;
	localparam int COST_W      = 24;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 20;

	// Wide coordinates lose their low bits before the square root.
	localparam int SHIFT  = (COORD_WIDTH > 24) ? (COORD_WIDTH - 24) : 0;
	localparam int AX_W   = COORD_WIDTH - SHIFT;
	localparam int SQ_W   = 2 * AX_W + 2;
	localparam int RT_W   = AX_W + 1;
	localparam int QT_W   = RT_W + SHIFT + 16;
	localparam int CD_W   = 41;
	localparam int OV_W   = EXT_W + 1;
	localparam int VOL_W  = 3 * EXT_W + 3;
	localparam int UNI_W  = VOL_W + 1;
	localparam int CO_W   = 17;
	localparam int EDGE_W = ((COORD_WIDTH + 1 > EXT_W + 1) ? (COORD_WIDTH + 1) : (EXT_W + 1)) + 1;

	// Depth of the queue between front and back; a power of two.
	localparam int QUEUE_DEPTH = 4;

	localparam logic [WGT_W-1:0]  WEIGHT_DISTANCE_RST = WGT_W'(4096);
	localparam logic [WGT_W-1:0]  WEIGHT_OVERLAP_RST  = WGT_W'(4096);
	localparam logic [GATE_W-1:0] DISTANCE_GATE_RST   = GATE_W'(1280);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_WEIGHT_DISTANCE = 2'd0,
		CFG_WEIGHT_OVERLAP  = 2'd1,
		CFG_DISTANCE_GATE   = 2'd2
	} tdwc_cfg_idx_t;

	typedef struct packed {
		logic signed [COORD_WIDTH-1:0] trk_x;
		logic signed [COORD_WIDTH-1:0] trk_y;
		logic signed [COORD_WIDTH-1:0] trk_z;
		logic [EXT_W-1:0]              trk_len;
		logic [EXT_W-1:0]              trk_wid;
		logic [EXT_W-1:0]              trk_hgt;
		logic signed [COORD_WIDTH-1:0] det_x;
		logic signed [COORD_WIDTH-1:0] det_y;
		logic signed [COORD_WIDTH-1:0] det_z;
		logic [EXT_W-1:0]              det_len;
		logic [EXT_W-1:0]              det_wid;
		logic [EXT_W-1:0]              det_hgt;
	} tdwc_in_t;

	typedef struct packed {
		logic [COST_W-1:0] assoc_cost;
		logic              cost_saturated;
	} tdwc_out_t;

	// Geometry of one item as handed from the front to the back.
	typedef struct packed {
		logic [SQ_W-1:0]  sq;
		logic [VOL_W-1:0] inter;
		logic [VOL_W-1:0] vt;
		logic [VOL_W-1:0] vd;
	} tdwc_geom_t;

	typedef struct packed {
		logic [WGT_W-1:0]  wd;
		logic [WGT_W-1:0]  wo;
		logic [GATE_W-1:0] gate;
	} tdwc_cfg_t;

endpackage

/* design/tdwc_front.sv */
// Front pipeline: reduces accepted items to squared distance, overlap and box volumes.
`timescale 1ns / 1ps

module tdwc_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  tdwc_pkg::tdwc_in_t   in_data,
	input  logic                 q_full,
	output logic                 q_push,
	output tdwc_pkg::tdwc_geom_t q_data
);
	import tdwc_pkg::*;

	localparam int EXT2_W = 2 * EXT_W;
	localparam int OV2_W  = 2 * OV_W;
	localparam int AXSQ_W = 2 * AX_W;

	logic signed [COORD_WIDTH-1:0] tc [3];
	logic signed [COORD_WIDTH-1:0] dc [3];
	logic [EXT_W-1:0]              te [3];
	logic [EXT_W-1:0]              de [3];
	logic signed [COORD_WIDTH:0]   diff [3];
	logic [COORD_WIDTH:0]          mag [3];
	logic [EDGE_W-1:0]             tc2 [3];
	logic [EDGE_W-1:0]             dc2 [3];
	logic [EDGE_W-1:0]             tex [3];
	logic [EDGE_W-1:0]             dex [3];
	logic signed [EDGE_W-1:0]      hi [3];
	logic signed [EDGE_W-1:0]      lo [3];
	logic signed [EDGE_W-1:0]      span [3];
	logic [OV_W-1:0]               ov [3];
	logic                          fe_en;

	logic                          vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic [AX_W-1:0]               ad_s1 [3];
	logic signed [EDGE_W-1:0]      alo_s1 [3];
	logic signed [EDGE_W-1:0]      ahi_s1 [3];
	logic signed [EDGE_W-1:0]      blo_s1 [3];
	logic signed [EDGE_W-1:0]      bhi_s1 [3];
	logic [EXT_W-1:0]              te_s1 [3];
	logic [EXT_W-1:0]              de_s1 [3];
	logic [OV_W-1:0]               ov_s2 [3];
	logic [AXSQ_W-1:0]             dsq_s2 [3];
	logic [EXT2_W-1:0]             tp_s2, dp_s2;
	logic [EXT_W-1:0]              te2_s2, de2_s2;
	logic [SQ_W-1:0]               sq_s3, sq_s4;
	logic [OV2_W-1:0]              ov01_s3;
	logic [OV_W-1:0]               ov2_s3;
	logic [EXT2_W-1:0]             tlo_s3, thi_s3, dlo_s3, dhi_s3;
	logic [OV2_W-1:0]              ilo_s4, ihi_s4;
	logic [VOL_W-1:0]              vt_s4, vd_s4;
	logic [3*EXT_W-1:0]            tsum, dsum;
	tdwc_geom_t                    rec_s5;

	assign tc[0] = in_data.trk_x;
	assign tc[1] = in_data.trk_y;
	assign tc[2] = in_data.trk_z;
	assign dc[0] = in_data.det_x;
	assign dc[1] = in_data.det_y;
	assign dc[2] = in_data.det_z;
	assign te[0] = in_data.trk_len;
	assign te[1] = in_data.trk_wid;
	assign te[2] = in_data.trk_hgt;
	assign de[0] = in_data.det_len;
	assign de[1] = in_data.det_wid;
	assign de[2] = in_data.det_hgt;

	// The whole front moves unless its last item cannot enter the queue.
	assign fe_en    = !vld_s5 || !q_full;
	assign in_ready = fe_en;
	assign q_push   = vld_s5 && !q_full;
	assign q_data   = rec_s5;

	always_comb begin
		for (int a = 0; a < 3; a++) begin
			diff[a] = {tc[a][COORD_WIDTH-1], tc[a]} - {dc[a][COORD_WIDTH-1], dc[a]};
			mag[a]  = diff[a][COORD_WIDTH] ? (~diff[a] + 1'b1) : diff[a];
			tc2[a]  = {{(EDGE_W-COORD_WIDTH-1){tc[a][COORD_WIDTH-1]}}, tc[a], 1'b0};
			dc2[a]  = {{(EDGE_W-COORD_WIDTH-1){dc[a][COORD_WIDTH-1]}}, dc[a], 1'b0};
			tex[a]  = {{(EDGE_W-EXT_W){1'b0}}, te[a]};
			dex[a]  = {{(EDGE_W-EXT_W){1'b0}}, de[a]};
		end
	end

	// Overlap along each axis, in half units of the input grid.
	always_comb begin
		for (int a = 0; a < 3; a++) begin
			hi[a]   = (ahi_s1[a] < bhi_s1[a]) ? ahi_s1[a] : bhi_s1[a];
			lo[a]   = (alo_s1[a] > blo_s1[a]) ? alo_s1[a] : blo_s1[a];
			span[a] = hi[a] - lo[a];
			ov[a]   = (hi[a] > lo[a]) ? span[a][OV_W-1:0] : '0;
		end
	end

	assign tsum = {thi_s3, {EXT_W{1'b0}}} + (3*EXT_W)'(tlo_s3);
	assign dsum = {dhi_s3, {EXT_W{1'b0}}} + (3*EXT_W)'(dlo_s3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else if (fe_en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (fe_en) begin
			for (int a = 0; a < 3; a++) begin
				ad_s1[a]  <= mag[a][COORD_WIDTH-1:SHIFT];
				alo_s1[a] <= tc2[a] - tex[a];
				ahi_s1[a] <= tc2[a] + tex[a];
				blo_s1[a] <= dc2[a] - dex[a];
				bhi_s1[a] <= dc2[a] + dex[a];
				te_s1[a]  <= te[a];
				de_s1[a]  <= de[a];
				ov_s2[a]  <= ov[a];
				dsq_s2[a] <= AXSQ_W'(ad_s1[a]) * AXSQ_W'(ad_s1[a]);
			end
			tp_s2   <= EXT2_W'(te_s1[0]) * EXT2_W'(te_s1[1]);
			dp_s2   <= EXT2_W'(de_s1[0]) * EXT2_W'(de_s1[1]);
			te2_s2  <= te_s1[2];
			de2_s2  <= de_s1[2];

			sq_s3   <= SQ_W'(dsq_s2[0]) + SQ_W'(dsq_s2[1]) + SQ_W'(dsq_s2[2]);
			ov01_s3 <= OV2_W'(ov_s2[0]) * OV2_W'(ov_s2[1]);
			ov2_s3  <= ov_s2[2];
			tlo_s3  <= EXT2_W'(tp_s2[EXT_W-1:0]) * EXT2_W'(te2_s2);
			thi_s3  <= EXT2_W'(tp_s2[EXT2_W-1:EXT_W]) * EXT2_W'(te2_s2);
			dlo_s3  <= EXT2_W'(dp_s2[EXT_W-1:0]) * EXT2_W'(de2_s2);
			dhi_s3  <= EXT2_W'(dp_s2[EXT2_W-1:EXT_W]) * EXT2_W'(de2_s2);

			sq_s4   <= sq_s3;
			ilo_s4  <= OV2_W'(ov01_s3[OV_W-1:0]) * OV2_W'(ov2_s3);
			ihi_s4  <= OV2_W'(ov01_s3[OV2_W-1:OV_W]) * OV2_W'(ov2_s3);
			vt_s4   <= VOL_W'({tsum, 3'b000});
			vd_s4   <= VOL_W'({dsum, 3'b000});

			rec_s5.sq    <= sq_s4;
			rec_s5.inter <= VOL_W'({ihi_s4, {OV_W{1'b0}}}) + VOL_W'(ilo_s4);
			rec_s5.vt    <= vt_s4;
			rec_s5.vd    <= vd_s4;
		end
	end

endmodule

/* design/tdwc_queue.sv */
// Small register queue that decouples the front and back pipelines.
`timescale 1ns / 1ps

module tdwc_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  tdwc_pkg::tdwc_geom_t push_data,
	output logic                 full,
	input  logic                 pop,
	output tdwc_pkg::tdwc_geom_t pop_data,
	output logic                 empty
);
	import tdwc_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);

	tdwc_geom_t       entry_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [PTR_W:0]   count_q;

	assign full     = (count_q == (PTR_W+1)'(QUEUE_DEPTH));
	assign empty    = (count_q == '0);
	assign pop_data = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

/* design/tdwc_back.sv */
// Back pipeline: square root, gate division, one minus IoU and the weighted sum.
`timescale 1ns / 1ps

module tdwc_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  tdwc_pkg::tdwc_cfg_t  cfg,
	input  logic                 q_empty,
	input  tdwc_pkg::tdwc_geom_t q_data,
	output logic                 q_pop,
	output logic                 out_valid,
	input  logic                 out_ready,
	output tdwc_pkg::tdwc_out_t  out_data
);
	import tdwc_pkg::*;

	localparam int TC     = RT_W + QT_W + 1;
	localparam int NB     = TC + 2;
	localparam int DL     = TC - 18;
	localparam int CMP_W  = (QT_W > CD_W) ? QT_W : CD_W;
	localparam int SUM_W  = WGT_W + CD_W + 1;
	localparam int TOT_W  = SUM_W - 12;
	localparam int LO_W   = 21;
	localparam int HI_W   = CD_W - LO_W;
	localparam logic [CMP_W-1:0] CD_LIM = CMP_W'(1) << (CD_W - 1);
	localparam logic [CO_W-1:0]  CO_ONE = CO_W'(1) << 16;

	logic                en;
	logic [NB-1:0]       vld_q;

	// Square root stages.
	logic [SQ_W-1:0]     sr_rad_s [RT_W];
	logic [RT_W+1:0]     sr_rem_s [RT_W];
	logic [RT_W-1:0]     sr_root_s [RT_W];
	logic [SQ_W-1:0]     sr_rad_d [RT_W];
	logic [RT_W+1:0]     sr_rem_d [RT_W];
	logic [RT_W-1:0]     sr_root_d [RT_W];

	// Division by the gate, one quotient bit per stage.
	logic [QT_W-1:0]     dv_num_s [QT_W];
	logic [GATE_W-1:0]   dv_rem_s [QT_W];
	logic [QT_W-1:0]     dv_num_d [QT_W];
	logic [GATE_W-1:0]   dv_rem_d [QT_W];

	// Overlap ratio stages.
	logic [UNI_W-1:0]    uni_s1;
	logic [VOL_W-1:0]    inter_s1;
	logic [UNI_W-1:0]    rt_den_s [17];
	logic [UNI_W-1:0]    rt_rem_s [17];
	logic [CO_W-1:0]     rt_q_s [17];
	logic                rt_zero_s [17];
	logic [UNI_W-1:0]    rt_rem_d [17];
	logic [CO_W-1:0]     rt_q_d [17];
	logic [CO_W-1:0]     co_s [DL];

	logic [CMP_W-1:0]    qx;
	logic [CD_W-1:0]     cd_s;
	logic [WGT_W+LO_W-1:0] pd_lo_s;
	logic [WGT_W+HI_W-1:0] pd_hi_s;
	logic [WGT_W+CO_W-1:0] po_s;
	logic [SUM_W-1:0]    sum;
	logic [TOT_W-1:0]    total;
	tdwc_out_t           out_s;

	// Every stage moves together; only a stalled result holds the back.
	assign en        = !vld_q[NB-1] || out_ready;
	assign q_pop     = en && !q_empty;
	assign out_valid = vld_q[NB-1];
	assign out_data  = out_s;

	always_comb begin
		logic [SQ_W-1:0]  rad;
		logic [RT_W+1:0]  rem;
		logic [RT_W-1:0]  root;
		logic [RT_W+3:0]  cur;
		logic [RT_W+3:0]  sub;
		for (int k = 0; k < RT_W; k++) begin
			if (k == 0) begin
				rad  = q_data.sq;
				rem  = '0;
				root = '0;
			end else begin
				rad  = sr_rad_s[k-1];
				rem  = sr_rem_s[k-1];
				root = sr_root_s[k-1];
			end
			cur = {rem, rad[SQ_W-1 -: 2]};
			sub = (RT_W+4)'({root, 2'b01});
			if (cur >= sub) begin
				sr_rem_d[k]  = (RT_W+2)'(cur - sub);
				sr_root_d[k] = {root[RT_W-2:0], 1'b1};
			end else begin
				sr_rem_d[k]  = (RT_W+2)'(cur);
				sr_root_d[k] = {root[RT_W-2:0], 1'b0};
			end
			sr_rad_d[k] = {rad[SQ_W-3:0], 2'b00};
		end
	end

	always_comb begin
		logic [QT_W-1:0]   num;
		logic [GATE_W-1:0] rem;
		logic [GATE_W:0]   cur;
		logic              take;
		for (int k = 0; k < QT_W; k++) begin
			if (k == 0) begin
				num = {sr_root_s[RT_W-1], {(SHIFT+16){1'b0}}};
				rem = '0;
			end else begin
				num = dv_num_s[k-1];
				rem = dv_rem_s[k-1];
			end
			cur         = {rem, num[QT_W-1]};
			take        = (cur >= (GATE_W+1)'(cfg.gate));
			dv_rem_d[k] = take ? GATE_W'(cur - (GATE_W+1)'(cfg.gate)) : GATE_W'(cur);
			dv_num_d[k] = {num[QT_W-2:0], take};
		end
	end

	// Remainder stays below the union, so doubling it needs one extra bit.
	always_comb begin
		logic [UNI_W:0] twice;
		logic           take;
		rt_rem_d[0] = (inter_s1 == '0) ? '0 : (uni_s1 - UNI_W'(inter_s1));
		rt_q_d[0]   = (inter_s1 == '0) ? CO_W'(1) : '0;
		for (int k = 1; k < 17; k++) begin
			twice       = {rt_rem_s[k-1], 1'b0};
			take        = (twice >= (UNI_W+1)'(rt_den_s[k-1]));
			rt_rem_d[k] = take ? UNI_W'(twice - (UNI_W+1)'(rt_den_s[k-1])) : UNI_W'(twice);
			rt_q_d[k]   = {rt_q_s[k-1][CO_W-2:0], take};
		end
	end

	assign qx    = CMP_W'(dv_num_s[QT_W-1]);
	assign sum   = (SUM_W'(pd_hi_s) << LO_W) + SUM_W'(pd_lo_s) + SUM_W'(po_s);
	assign total = sum[SUM_W-1:12];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[NB-2:0], q_pop};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < RT_W; k++) begin
				sr_rad_s[k]  <= sr_rad_d[k];
				sr_rem_s[k]  <= sr_rem_d[k];
				sr_root_s[k] <= sr_root_d[k];
			end
			for (int k = 0; k < QT_W; k++) begin
				dv_num_s[k] <= dv_num_d[k];
				dv_rem_s[k] <= dv_rem_d[k];
			end

			uni_s1   <= UNI_W'(q_data.vt) + UNI_W'(q_data.vd) - UNI_W'(q_data.inter);
			inter_s1 <= q_data.inter;
			rt_den_s[0]  <= uni_s1;
			rt_zero_s[0] <= (uni_s1 == '0);
			for (int k = 1; k < 17; k++) begin
				rt_den_s[k]  <= rt_den_s[k-1];
				rt_zero_s[k] <= rt_zero_s[k-1];
			end
			for (int k = 0; k < 17; k++) begin
				rt_rem_s[k] <= rt_rem_d[k];
				rt_q_s[k]   <= rt_q_d[k];
			end

			co_s[0] <= rt_zero_s[16] ? CO_ONE : rt_q_s[16];
			for (int j = 1; j < DL; j++) begin
				co_s[j] <= co_s[j-1];
			end

			cd_s    <= (qx > CD_LIM) ? CD_W'(CD_LIM) : CD_W'(qx);
			pd_lo_s <= (WGT_W+LO_W)'(cfg.wd) * (WGT_W+LO_W)'(cd_s[LO_W-1:0]);
			pd_hi_s <= (WGT_W+HI_W)'(cfg.wd) * (WGT_W+HI_W)'(cd_s[CD_W-1:LO_W]);
			po_s    <= (WGT_W+CO_W)'(cfg.wo) * (WGT_W+CO_W)'(co_s[DL-1]);

			out_s.cost_saturated <= |total[TOT_W-1:COST_W];
			out_s.assoc_cost     <= (|total[TOT_W-1:COST_W]) ? '1 : total[COST_W-1:0];
		end
	end

endmodule

/* design/track_detection_weighted_cost_unit.sv */
// Top level of the track/detection weighted association cost unit.
`timescale 1ns / 1ps

// The unit scores one track box against one detection box per item and returns one
// cost item per input item, in order. Input items arrive on in_valid/in_ready with the
// payload in in_data; results leave on out_valid/out_ready with out_data. The cost is
// the distance weight times the centre distance over the gate, plus the overlap weight
// times one minus the axis-aligned 3D IoU, in unsigned Q8.16, saturated with a flag.
//
// One item is accepted per clock unless a full queue holds the front. Results leave
// a pipeline made mostly of the digit-by-digit square root (one result bit per stage)
// followed by the division by the gate (one quotient bit per stage).
//
// When the receiver stalls, the back pipeline holds, the four-entry queue in front of it
// fills, and then the front stops taking items. Reset empties every stage and the queue
// and loads the registers with weights of 1.0 and a gate of 5.0. The user must write
// the three registers over cfg_we/cfg_idx/cfg_data only while no item is in flight, which
// the unit does not enforce. A zero gate is the smallest gate; other indices are ignored.
module track_detection_weighted_cost_unit (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [tdwc_pkg::CFG_IDX_W-1:0]   cfg_idx,
	input  logic [tdwc_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  tdwc_pkg::tdwc_in_t               in_data,
	output logic                             out_valid,
	input  logic                             out_ready,
	output tdwc_pkg::tdwc_out_t              out_data
);
	import tdwc_pkg::*;

	tdwc_cfg_t  cfg_q;
	tdwc_geom_t push_data;
	tdwc_geom_t pop_data;
	logic       push;
	logic       pop;
	logic       full;
	logic       empty;

	// Configuration registers. The gate is stored already forced to at least one.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.wd   <= WEIGHT_DISTANCE_RST;
			cfg_q.wo   <= WEIGHT_OVERLAP_RST;
			cfg_q.gate <= DISTANCE_GATE_RST;
		end else if (cfg_we) begin
			unique case (tdwc_cfg_idx_t'(cfg_idx))
				CFG_WEIGHT_DISTANCE: cfg_q.wd <= cfg_data[WGT_W-1:0];
				CFG_WEIGHT_OVERLAP:  cfg_q.wo <= cfg_data[WGT_W-1:0];
				CFG_DISTANCE_GATE:   cfg_q.gate <= (cfg_data[GATE_W-1:0] == '0) ?
					GATE_W'(1) : cfg_data[GATE_W-1:0];
				default: ;
			endcase
		end
	end

	// The front turns each item into a squared centre distance, the intersection volume
	// and the two box volumes.
	tdwc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.q_full   (full),
		.q_push   (push),
		.q_data   (push_data)
	);

	// The queue lets the front keep going for a few items while the back is held.
	tdwc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (pop),
		.pop_data  (pop_data),
		.empty     (empty)
	);

	// The back does the long iterative work and owns the output register.
	tdwc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_empty   (empty),
		.q_data    (pop_data),
		.q_pop     (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

/* tb/track_detection_weighted_cost_unit_tb.sv */
// Self-checking testbench of the track/detection weighted association cost unit.
`timescale 1ns / 1ps

// The bench drives box pairs over the input handshake and scores each pair without a
// given cost with its own copy of the arithmetic. It then checks each result item, in
// order, against the oldest cost still waiting. A short table of directed rows comes
// first. It covers zero boxes, identical boxes, extreme coordinates and extents, a zero
// gate, the distance clamp, zero weights and an ignored register index. Its rows are
// register writes or items, and a few items carry a cost typed in by hand. Random
// phases follow, each under its own register setting. Both sides stall at random. The
// receiver holds off once for a long stretch so that the unit fills up, and the sender
// drains the unit before every register write.
module track_detection_weighted_cost_unit_tb;
	import tdwc_pkg::*;

	localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED = 2'd3;
	localparam int IDLE_LIMIT = 3000;
	localparam int LONG_HOLD = 300;
	localparam int RANDOM_PHASES = 5;
	localparam int ITEMS_PER_PHASE = 100;

	typedef struct {
		bit                   is_write;
		logic [CFG_IDX_W-1:0] idx;
		logic [CFG_DATA_W-1:0] data;
		tdwc_in_t             pair;
		bit                   known;
		tdwc_out_t            want;
	} stim_row_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic in_valid;
	logic in_ready;
	tdwc_in_t in_data;
	logic out_valid;
	logic out_ready;
	tdwc_out_t out_data;

	// The bench's own copy of the three registers.
	logic [WGT_W-1:0] weight_dist;
	logic [WGT_W-1:0] weight_ovl;
	logic [GATE_W-1:0] gate_reg;

	tdwc_out_t cost_queue[$];
	stim_row_t rows[$];
	int failures;
	int idle_cycles;
	bit long_hold_req;

	track_detection_weighted_cost_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Floor of the square root, one result bit per step.
	function automatic longint unsigned floor_sqrt(longint unsigned v);
		longint unsigned root;
		longint unsigned bitv;
		root = 0;
		bitv = 64'd1 << 62;
		while (bitv > v)
			bitv >>= 2;
		while (bitv != 0) begin
			if (v >= root + bitv) begin
				v -= root + bitv;
				root = (root >> 1) + bitv;
			end else begin
				root >>= 1;
			end
			bitv >>= 2;
		end
		return root;
	endfunction

	// Overlap, doubled (units 2^-9), of two intervals given by centre and full extent.
	function automatic longint unsigned span_overlap(longint ca, longint la, longint cb,
			longint lb);
		longint hi;
		longint lo;
		hi = (2 * ca + la < 2 * cb + lb) ? 2 * ca + la : 2 * cb + lb;
		lo = (2 * ca - la > 2 * cb - lb) ? 2 * ca - la : 2 * cb - lb;
		return (hi > lo) ? longint'(hi - lo) : 0;
	endfunction

	// Weighted cost of one box pair under the current register copy.
	function automatic tdwc_out_t pair_cost(tdwc_in_t p);
		longint dx;
		longint dy;
		longint dz;
		longint unsigned ctr_dist;
		longint unsigned gate;
		longint unsigned dcost;
		longint unsigned ocost;
		longint unsigned inter;
		longint unsigned vol_t;
		longint unsigned vol_d;
		longint unsigned uni;
		logic [127:0] wide;
		tdwc_out_t r;
		dx = longint'(p.trk_x) - longint'(p.det_x);
		dy = longint'(p.trk_y) - longint'(p.det_y);
		dz = longint'(p.trk_z) - longint'(p.det_z);
		ctr_dist = floor_sqrt(dx * dx + dy * dy + dz * dz);
		gate = (gate_reg == 0) ? 1 : gate_reg;
		dcost = (ctr_dist << 16) / gate;
		if (dcost > (64'd1 << 40))
			dcost = 64'd1 << 40;
		inter = span_overlap(p.trk_x, p.trk_len, p.det_x, p.det_len)
			* span_overlap(p.trk_y, p.trk_wid, p.det_y, p.det_wid)
			* span_overlap(p.trk_z, p.trk_hgt, p.det_z, p.det_hgt);
		vol_t = 64'(p.trk_len) * 64'(p.trk_wid) * 64'(p.trk_hgt) * 8;
		vol_d = 64'(p.det_len) * 64'(p.det_wid) * 64'(p.det_hgt) * 8;
		uni = vol_t + (vol_d - inter);
		if (uni == 0) begin
			ocost = 64'd1 << 16;
		end else begin
			wide = (128'(uni - inter) << 16) / 128'(uni);
			ocost = wide[63:0];
		end
		wide = (128'(weight_dist) * dcost + 128'(weight_ovl) * ocost) >> 12;
		if (wide > 128'hFFFFFF) begin
			r.assoc_cost = '1;
			r.cost_saturated = 1'b1;
		end else begin
			r.assoc_cost = wide[COST_W-1:0];
			r.cost_saturated = 1'b0;
		end
		return r;
	endfunction

	function automatic tdwc_in_t make_pair(int tx, int ty, int tz, int tl, int tw, int th,
			int dx, int dy, int dz, int dl, int dw, int dh);
		tdwc_in_t p;
		p.trk_x = COORD_WIDTH'(tx);
		p.trk_y = COORD_WIDTH'(ty);
		p.trk_z = COORD_WIDTH'(tz);
		p.trk_len = EXT_W'(tl);
		p.trk_wid = EXT_W'(tw);
		p.trk_hgt = EXT_W'(th);
		p.det_x = COORD_WIDTH'(dx);
		p.det_y = COORD_WIDTH'(dy);
		p.det_z = COORD_WIDTH'(dz);
		p.det_len = EXT_W'(dl);
		p.det_wid = EXT_W'(dw);
		p.det_hgt = EXT_W'(dh);
		return p;
	endfunction

	function automatic int pick_coord();
		case ($urandom_range(0, 5))
			0: return -8388608;
			1: return 8388607;
			2: return $urandom_range(0, 4095) - 2048;
			default: return int'($urandom) >>> 8;
		endcase
	endfunction

	function automatic int pick_extent();
		case ($urandom_range(0, 7))
			0: return 0;
			1: return 20'hFFFFF;
			2: return $urandom_range(0, 20'hFFFFF);
			default: return $urandom_range(1, 4095);
		endcase
	endfunction

	// Mostly nearby boxes of similar size so that the overlap term varies widely;
	// the rest are independent boxes anywhere in the coordinate range.
	function automatic tdwc_in_t random_pair();
		tdwc_in_t p;
		p = make_pair(pick_coord(), pick_coord(), pick_coord(),
			pick_extent(), pick_extent(), pick_extent(),
			pick_coord(), pick_coord(), pick_coord(),
			pick_extent(), pick_extent(), pick_extent());
		if ($urandom_range(0, 9) < 7) begin
			p.det_x = COORD_WIDTH'(p.trk_x + ($urandom_range(0, 2047) - 1024));
			p.det_y = COORD_WIDTH'(p.trk_y + ($urandom_range(0, 2047) - 1024));
			p.det_z = COORD_WIDTH'(p.trk_z + ($urandom_range(0, 2047) - 1024));
			p.det_len = EXT_W'(p.trk_len + $urandom_range(0, 511));
			p.det_wid = EXT_W'(p.trk_wid + $urandom_range(0, 511));
			p.det_hgt = EXT_W'(p.trk_hgt + $urandom_range(0, 511));
		end
		return p;
	endfunction

	function automatic int pick_weight();
		case ($urandom_range(0, 4))
			0: return 0;
			1: return 16'hFFFF;
			2: return 4096;
			default: return $urandom_range(0, 16'hFFFF);
		endcase
	endfunction

	function automatic int pick_gate();
		case ($urandom_range(0, 5))
			0: return 0;
			1: return 1;
			2: return 20'hFFFFF;
			3: return $urandom_range(1, 20'hFFFFF);
			default: return $urandom_range(1, 8192);
		endcase
	endfunction

	function automatic void add_write(logic [CFG_IDX_W-1:0] idx, int data);
		stim_row_t r;
		r = '{default: '0};
		r.is_write = 1'b1;
		r.idx = idx;
		r.data = CFG_DATA_W'(data);
		rows.push_back(r);
	endfunction

	function automatic void add_item(tdwc_in_t p, bit known, int cost, bit sat);
		stim_row_t r;
		r = '{default: '0};
		r.pair = p;
		r.known = known;
		r.want.assoc_cost = COST_W'(cost);
		r.want.cost_saturated = sat;
		rows.push_back(r);
	endfunction

	// Waits until every cost has come back, so that a register may be written.
	task automatic drain();
		while (cost_queue.size() != 0)
			@(posedge clk);
		repeat (5) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		in_valid <= 1'b0;
		drain();
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_WEIGHT_DISTANCE: weight_dist = data[WGT_W-1:0];
			CFG_WEIGHT_OVERLAP:  weight_ovl = data[WGT_W-1:0];
			CFG_DISTANCE_GATE:   gate_reg = data[GATE_W-1:0];
			default: ;
		endcase
	endtask

	// Offers one item, returns after the edge that accepts it and a random gap. The valid
	// line stays high unless that gap lowers it.
	task automatic send_item(tdwc_in_t p, tdwc_out_t want);
		int gap;
		in_valid <= 1'b1;
		in_data <= p;
		do
			@(posedge clk);
		while (!in_ready);
		cost_queue.push_back(want);
		gap = ($urandom_range(0, 1) == 0) ? 0
			: ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(20, 50);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Stimulus: directed table, then random phases.
	initial begin
		tdwc_out_t want;
		tdwc_in_t pair;
		int n;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		in_data = '0;
		failures = 0;
		long_hold_req = 1'b0;
		weight_dist = WEIGHT_DISTANCE_RST;
		weight_ovl = WEIGHT_OVERLAP_RST;
		gate_reg = DISTANCE_GATE_RST;

		// Two empty boxes: the union is zero, so the overlap cost is one.
		add_item(make_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, 65536, 0);
		// Identical boxes cost nothing.
		add_item(make_pair(0, 0, 0, 256, 256, 256, 0, 0, 0, 256, 256, 256), 1, 0, 0);
		// Coordinates at both ends of the range saturate the sum.
		add_item(make_pair(-8388608, 0, 0, 0, 0, 0, 8388607, 0, 0, 0, 0, 0), 1,
			24'hFFFFFF, 1);
		// The largest boxes, fully overlapping.
		add_item(make_pair(5, -7, 9, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF,
			5, -7, 9, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF), 1, 0, 0);
		add_item(make_pair(0, 0, 0, 512, 512, 512, 2000, 0, 0, 512, 512, 512), 0, 0, 0);
		add_item(make_pair(100, -50, 30, 600, 400, 300, -20, 60, 0, 500, 700, 200), 0, 0, 0);
		add_item(make_pair(-1, -1, -1, 20'hFFFFF, 1, 20'hFFFFF, -1, -2, -3, 1, 20'hFFFFF, 7),
			0, 0, 0);
		add_item(make_pair(8388607, 8388607, 8388607, 0, 0, 0, -1, -1, -1, 0, 0, 0), 0, 0, 0);
		// A zero gate counts as the smallest gate; the diagonal hits the clamp.
		add_write(CFG_DISTANCE_GATE, 0);
		add_item(make_pair(-8388608, -8388608, -8388608, 0, 0, 0,
			8388607, 8388607, 8388607, 0, 0, 0), 1, 24'hFFFFFF, 1);
		add_item(make_pair(0, 0, 0, 10, 10, 10, 0, 0, 0, 10, 10, 10), 1, 0, 0);
		// With no distance weight, far empty boxes cost exactly one.
		add_write(CFG_WEIGHT_DISTANCE, 0);
		add_item(make_pair(-8388608, -8388608, -8388608, 0, 0, 0,
			8388607, 8388607, 8388607, 0, 0, 0), 1, 65536, 0);
		add_write(CFG_WEIGHT_OVERLAP, 0);
		add_item(make_pair(-8388608, 3, 0, 0, 9, 0, 8388607, 0, 5, 4, 0, 0), 1, 0, 0);
		add_write(CFG_WEIGHT_DISTANCE, 16'hFFFF);
		add_write(CFG_WEIGHT_OVERLAP, 16'hFFFF);
		add_write(CFG_DISTANCE_GATE, 20'hFFFFF);
		add_item(make_pair(300, 200, -100, 800, 800, 800, 0, 0, 0, 900, 700, 600), 0, 0, 0);
		// A write beyond the register list changes nothing.
		add_write(CFG_IDX_UNUSED, 20'hFFFFF);
		add_item(make_pair(-3000, 40, 7, 1000, 2000, 3000, -2500, 0, 0, 1500, 2500, 100),
			0, 0, 0);
		add_write(CFG_WEIGHT_DISTANCE, 4096);
		add_write(CFG_WEIGHT_OVERLAP, 4096);
		add_write(CFG_DISTANCE_GATE, 1280);

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i]) begin
			if (rows[i].is_write) begin
				write_reg(rows[i].idx, rows[i].data);
			end else begin
				want = rows[i].known ? rows[i].want : pair_cost(rows[i].pair);
				send_item(rows[i].pair, want);
			end
		end

		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			// The sender waits here until every cost has come back.
			write_reg(CFG_WEIGHT_DISTANCE, CFG_DATA_W'(pick_weight()));
			write_reg(CFG_WEIGHT_OVERLAP, CFG_DATA_W'(pick_weight()));
			write_reg(CFG_DISTANCE_GATE, CFG_DATA_W'(pick_gate()));
			for (n = 0; n < ITEMS_PER_PHASE; n++) begin
				if (ph == 1 && n == 10)
					long_hold_req = 1'b1;
				// A burst without gaps while the receiver holds off fills the unit.
				if (ph == 1 && n >= 10 && n < 100) begin
					in_valid <= 1'b1;
					in_data <= random_pair();
					do
						@(posedge clk);
					while (!in_ready);
					cost_queue.push_back(pair_cost(in_data));
				end else begin
					pair = random_pair();
					send_item(pair, pair_cost(pair));
				end
			end
		end
		in_valid <= 1'b0;
		drain();
		repeat (100) @(posedge clk);
		if (failures == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	// Receiver: runs of ready, short and occasionally long stalls, and one long hold-off.
	// A hold-off request cuts the current run short so that it starts at once.
	initial begin
		int run;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				out_ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end
			run = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150) : $urandom_range(1, 20);
			out_ready <= 1'b1;
			for (int c = 0; c < run && !long_hold_req; c++)
				@(posedge clk);
			run = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 3) : $urandom_range(20, 60);
			if (run > 0 && !long_hold_req) begin
				out_ready <= 1'b0;
				for (int c = 0; c < run && !long_hold_req; c++)
					@(posedge clk);
			end
		end
	end

	// Result checker and watchdog.
	always @(posedge clk) begin
		tdwc_out_t want;
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles > IDLE_LIMIT) begin
				$display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
				$display("== FAIL ==");
				$finish;
			end
		end else begin
			idle_cycles <= 0;
		end
		if (out_valid && out_ready) begin
			if (cost_queue.size() == 0) begin
				$display("%0t: unexpected result, actual cost %0d sat %0b", $time,
					out_data.assoc_cost, out_data.cost_saturated);
				failures++;
			end else begin
				want = cost_queue.pop_front();
				if (out_data.assoc_cost !== want.assoc_cost) begin
					$display("%0t: assoc_cost expected %0d actual %0d", $time,
						want.assoc_cost, out_data.assoc_cost);
					failures++;
				end
				if (out_data.cost_saturated !== want.cost_saturated) begin
					$display("%0t: cost_saturated expected %0b actual %0b", $time,
						want.cost_saturated, out_data.cost_saturated);
					failures++;
				end
			end
		end
	end

endmodule

/* filelist.f */
design/tdwc_pkg.sv
design/tdwc_front.sv
design/tdwc_queue.sv
design/tdwc_back.sv
design/track_detection_weighted_cost_unit.sv
tb/track_detection_weighted_cost_unit_tb.sv
